// ===== hw/rtl/token_bucket_shaper_core_defines.svh =====
// Assertion macros shared by the token bucket shaper RTL.
`ifndef TOKEN_BUCKET_SHAPER_CORE_DEFINES_SVH
`define TOKEN_BUCKET_SHAPER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, masked during reset.
`define TBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, masked during reset.
`define TBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tbs_pkg.sv =====
// Types and constants for the token bucket shaper.
package tbs_pkg;

   localparam int TOKEN_W  = 16;
   localparam int NUM_W    = 16;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 3;

   localparam logic [TOKEN_W-1:0] DEPTH_RESET = 16'd10;

   // Input op codes
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_TOKEN_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOKEN_DROPPED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PKT_QUEUED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_PKT_TOO_BIG   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_PKT_Q_FULL    = 3'd4;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_MOVE
   } tbs_state_type;

   // One waiting packet
   typedef struct packed {
      logic [TOKEN_W-1:0] need;
      logic [NUM_W-1:0]   number;
   } tbs_entry_type;

   // Per-cell control
   typedef struct packed {
      logic load;
      logic shift;
   } tbs_cell_ctrl_type;

endpackage

// ===== hw/rtl/tbs_cell.sv =====
// One queue cell: holds a waiting packet, loads at the tail, shifts toward the head.
module tbs_cell (
   input  logic                       clock,
   input  tbs_pkg::tbs_cell_ctrl_type ctrl,
   input  tbs_pkg::tbs_entry_type     load_data,
   input  tbs_pkg::tbs_entry_type     next_data,
   output tbs_pkg::tbs_entry_type     data
);

   tbs_pkg::tbs_entry_type entry_ff;
   tbs_pkg::tbs_entry_type entry_in;

   // shift takes the neighbor's packet, load takes a new arrival
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = next_data;
      end else if (ctrl.load) begin
         entry_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;

endmodule

// ===== hw/rtl/token_bucket_shaper_core.sv =====
// Token bucket shaper top level: bucket, counters, cell chain queue and result register.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | req_op, req_tokens_needed
//  rsp     | out | rsp_valid/rsp_stall | status, level, move, numbers, counts
//  csr     | in  | csr_valid/csr_ready | csr_bucket_depth
//
// Each beat: the accept in ST_IDLE applies the tick or arrival and loads the tail
// cell, and ST_MOVE then checks the head cell and shifts the chain.
// ST_MOVE waits while the result register is full and stalled.
// Synchronous active-high reset; depth resets to 10, queue cells are not cleared.
// csr_ready is always high; the depth takes effect on the next beat.
`include "token_bucket_shaper_core_defines.svh"

module token_bucket_shaper_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tbs_pkg::TOKEN_W-1:0]       csr_bucket_depth,
   // requests
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [tbs_pkg::TOKEN_W-1:0]       req_tokens_needed,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tbs_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tbs_pkg::TOKEN_W-1:0]       rsp_bucket_level,
   output logic                              rsp_moved,
   output logic [tbs_pkg::NUM_W-1:0]         rsp_moved_packet_number,
   output logic [tbs_pkg::TOKEN_W-1:0]       rsp_moved_tokens,
   output logic [tbs_pkg::NUM_W-1:0]         rsp_arrival_number,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0] rsp_queue_count,
   output logic [tbs_pkg::TOKEN_W-1:0]       rsp_tokens_dropped_total,
   output logic [tbs_pkg::TOKEN_W-1:0]       rsp_packets_dropped_total
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   tbs_pkg::tbs_state_type state_ff, state_in;

   logic [tbs_pkg::TOKEN_W-1:0]  depth_ff, depth_in;
   logic [tbs_pkg::TOKEN_W-1:0]  bucket_ff, bucket_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [tbs_pkg::NUM_W-1:0]    next_num_ff, next_num_in;
   logic [tbs_pkg::TOKEN_W-1:0]  tok_drop_ff, tok_drop_in;
   logic [tbs_pkg::TOKEN_W-1:0]  pkt_drop_ff, pkt_drop_in;
   logic [tbs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [tbs_pkg::NUM_W-1:0]    arrival_ff, arrival_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tbs_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [tbs_pkg::TOKEN_W-1:0]  rsp_level_ff;
   logic                         rsp_moved_ff;
   logic [tbs_pkg::NUM_W-1:0]    rsp_mnum_ff;
   logic [tbs_pkg::TOKEN_W-1:0]  rsp_mtok_ff;
   logic [tbs_pkg::NUM_W-1:0]    rsp_arr_ff;
   logic [FILL_W-1:0]            rsp_qcount_ff;
   logic [tbs_pkg::TOKEN_W-1:0]  rsp_tdrop_ff;
   logic [tbs_pkg::TOKEN_W-1:0]  rsp_pdrop_ff;

   logic                         req_accept;
   logic                         finish;
   logic                         enq;
   logic                         do_move;
   logic                         move_clear;
   tbs_pkg::tbs_entry_type       new_entry;
   tbs_pkg::tbs_entry_type       cell_data [QUEUE_DEPTH];

   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbs_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = tbs_pkg::ST_MOVE;
            end
         end
         tbs_pkg::ST_MOVE: begin
            if (finish) begin
               state_in = tbs_pkg::ST_IDLE;
            end
         end
         default: state_in = tbs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         tbs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            finish    = 1'b0;
         end
         tbs_pkg::ST_MOVE: begin
            req_stall = 1'b1;
            finish    = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
            finish    = 1'b0;
         end
      endcase
   end

   // head check: queue not empty and bucket covers the head's need
   assign do_move = finish && (fill_ff != '0) && (cell_data[0].need <= bucket_ff);

   assign new_entry.need   = req_tokens_needed;
   assign new_entry.number = next_num_ff;

   // depth, bucket, counters and arrival handling
   always_comb begin
      depth_in    = depth_ff;
      bucket_in   = bucket_ff;
      fill_in     = fill_ff;
      next_num_in = next_num_ff;
      tok_drop_in = tok_drop_ff;
      pkt_drop_in = pkt_drop_ff;
      status_in   = status_ff;
      arrival_in  = arrival_ff;
      enq         = 1'b0;
      if (csr_valid && csr_ready) begin
         depth_in = csr_bucket_depth;
      end
      if (req_accept) begin
         arrival_in = '0;
         if (req_op == tbs_pkg::OP_TICK) begin
            if (bucket_ff >= depth_ff) begin
               tok_drop_in = tok_drop_ff + 1'b1;
               status_in   = tbs_pkg::STATUS_TOKEN_DROPPED;
            end else begin
               bucket_in = bucket_ff + 1'b1;
               status_in = tbs_pkg::STATUS_TOKEN_ADDED;
            end
         end else begin
            arrival_in  = next_num_ff;
            next_num_in = (next_num_ff == '1) ? tbs_pkg::NUM_W'(1) : next_num_ff + 1'b1;
            if (req_tokens_needed > depth_ff) begin
               pkt_drop_in = pkt_drop_ff + 1'b1;
               status_in   = tbs_pkg::STATUS_PKT_TOO_BIG;
            end else if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
               pkt_drop_in = pkt_drop_ff + 1'b1;
               status_in   = tbs_pkg::STATUS_PKT_Q_FULL;
            end else begin
               enq       = 1'b1;
               fill_in   = fill_ff + 1'b1;
               status_in = tbs_pkg::STATUS_PKT_QUEUED;
            end
         end
      end else if (do_move) begin
         bucket_in = bucket_ff - cell_data[0].need;
         fill_in   = fill_ff - 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbs_pkg::ST_IDLE;
         depth_ff     <= tbs_pkg::DEPTH_RESET;
         bucket_ff    <= '0;
         fill_ff      <= '0;
         next_num_ff  <= tbs_pkg::NUM_W'(1);
         tok_drop_ff  <= '0;
         pkt_drop_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         bucket_ff    <= bucket_in;
         fill_ff      <= fill_in;
         next_num_ff  <= next_num_in;
         tok_drop_ff  <= tok_drop_in;
         pkt_drop_ff  <= pkt_drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // beat payload registers
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      arrival_ff <= arrival_in;
      if (finish) begin
         rsp_status_ff <= status_ff;
         rsp_level_ff  <= bucket_in;
         rsp_moved_ff  <= do_move;
         rsp_mnum_ff   <= do_move ? cell_data[0].number : '0;
         rsp_mtok_ff   <= do_move ? cell_data[0].need : '0;
         rsp_arr_ff    <= arrival_ff;
         rsp_qcount_ff <= fill_in;
         rsp_tdrop_ff  <= tok_drop_ff;
         rsp_pdrop_ff  <= pkt_drop_ff;
      end
   end

   // cell chain, head at cell 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      tbs_pkg::tbs_cell_ctrl_type ctrl;
      tbs_pkg::tbs_entry_type     next_data;

      assign ctrl.load  = enq && (fill_ff == FILL_W'(i));
      assign ctrl.shift = do_move;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      tbs_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_data (new_entry),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = rsp_status_ff;
   assign rsp_bucket_level          = rsp_level_ff;
   assign rsp_moved                 = rsp_moved_ff;
   assign rsp_moved_packet_number   = rsp_mnum_ff;
   assign rsp_moved_tokens          = rsp_mtok_ff;
   assign rsp_arrival_number        = rsp_arr_ff;
   assign rsp_queue_count           = rsp_qcount_ff;
   assign rsp_tokens_dropped_total  = rsp_tdrop_ff;
   assign rsp_packets_dropped_total = rsp_pdrop_ff;

   // move fields are zero when nothing left the queue
   assign move_clear = (rsp_mtok_ff == '0) && (rsp_mnum_ff == '0);

   // checks
   `TBS_ASSERT_SAME(a_fill_bound, 1'b1, fill_ff <= FILL_W'(QUEUE_DEPTH), "queue fill overflow")
   `TBS_ASSERT_NEXT(a_accept_busy, req_accept, state_ff == tbs_pkg::ST_MOVE, "no head check")
   `TBS_ASSERT_NEXT(a_move_fill, do_move, fill_ff == $past(fill_ff) - FILL_W'(1), "no fill drop")
   `TBS_ASSERT_SAME(a_idle_move, rsp_valid && !rsp_moved, move_clear, "stray move data")

endmodule
